FILE: src/mqrm_pkg.sv
// Shared types and codes for the multi-queue ring mailbox.
// Used by the controller, the datapath, the top level and the checker.
`default_nettype none

package mqrm_pkg;

  localparam int QID_W    = 5;
  localparam int HANDLE_W = 32;
  localparam int SIZE_W   = 16;

  localparam int DEF_QUEUE_COUNT     = 16;
  localparam int DEF_STATIC_QUEUES   = 8;
  localparam int DEF_SLOTS_PER_QUEUE = 16;

  typedef enum logic [1:0] {
    MODE_SEND   = 2'd0,
    MODE_RECV   = 2'd1,
    MODE_CREATE = 2'd2,
    MODE_DELETE = 2'd3
  } mqrm_mode_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_BAD_ID  = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_NO_DATA = 2'd3
  } mqrm_status_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } mqrm_cmd_t;

endpackage

`default_nettype wire

FILE: src/multi_queue_ring_mailbox_unit.sv
// Top level of the multi-queue ring mailbox: controller plus datapath.
// Depends on mqrm_pkg, mqrm_ctrl and mqrm_datapath.
//
// A word is taken when start is high and busy is low. Every word passes through
// the accept cycle, an execute cycle that updates the ring pointers and claim
// flags and reads or writes the slot memory, and a response cycle in which
// done is high for a single cycle with status, allocated_queue, handle_out and
// size_out valid. The registered read of the slot memory sets the response
// cycle. busy stays high through the execute and response cycles, so a new
// word may be offered in the cycle after done. The receiver cannot stall: the
// result registers hold their values only until the next word executes. Slot
// contents come up undefined after reset and need no clearing pass; pointers
// and claim flags clear with rst.
`default_nettype none

module multi_queue_ring_mailbox_unit #(
  parameter int QUEUE_COUNT     = mqrm_pkg::DEF_QUEUE_COUNT,
  parameter int STATIC_QUEUES   = mqrm_pkg::DEF_STATIC_QUEUES,
  parameter int SLOTS_PER_QUEUE = mqrm_pkg::DEF_SLOTS_PER_QUEUE
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      mode,
  input  logic [mqrm_pkg::QID_W-1:0]      queue_sel,
  input  logic [mqrm_pkg::HANDLE_W-1:0]   message_handle,
  input  logic [mqrm_pkg::SIZE_W-1:0]     message_size,
  output logic                            done,
  output logic [1:0]                      status,
  output logic [mqrm_pkg::QID_W-1:0]      allocated_queue,
  output logic [mqrm_pkg::HANDLE_W-1:0]   handle_out,
  output logic [mqrm_pkg::SIZE_W-1:0]     size_out
);
  import mqrm_pkg::*;

  mqrm_cmd_t cmd;

  mqrm_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  mqrm_datapath #(
    .QUEUE_COUNT     (QUEUE_COUNT),
    .STATIC_QUEUES   (STATIC_QUEUES),
    .SLOTS_PER_QUEUE (SLOTS_PER_QUEUE)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .mode            (mode),
    .queue_sel       (queue_sel),
    .message_handle  (message_handle),
    .message_size    (message_size),
    .status          (status),
    .allocated_queue (allocated_queue),
    .handle_out      (handle_out),
    .size_out        (size_out)
  );

endmodule

`default_nettype wire

FILE: src/mqrm_ctrl.sv
// Controller of the mailbox: accepts a word, sequences execute and respond.
// Depends on mqrm_pkg for the command struct.
`default_nettype none

module mqrm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output logic              done,
  output mqrm_pkg::mqrm_cmd_t cmd
);
  import mqrm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_RESP = 3'b100
  } mqrm_state_t;

  mqrm_state_t state, state_next;

  always_comb begin
    state_next  = state;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    done        = 1'b0;
    busy        = 1'b1;
    case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.execute = 1'b1;
        state_next  = S_RESP;
      end
      S_RESP: begin
        done       = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

FILE: src/mqrm_datapath.sv
// Datapath of the mailbox: ring pointers, claim flags, slot memories, result.
// Depends on mqrm_pkg; driven by commands from mqrm_ctrl.
`default_nettype none

module mqrm_datapath #(
  parameter int QUEUE_COUNT     = mqrm_pkg::DEF_QUEUE_COUNT,
  parameter int STATIC_QUEUES   = mqrm_pkg::DEF_STATIC_QUEUES,
  parameter int SLOTS_PER_QUEUE = mqrm_pkg::DEF_SLOTS_PER_QUEUE
) (
  input  logic                            clk,
  input  logic                            rst,
  input  mqrm_pkg::mqrm_cmd_t             cmd,
  input  logic [1:0]                      mode,
  input  logic [mqrm_pkg::QID_W-1:0]      queue_sel,
  input  logic [mqrm_pkg::HANDLE_W-1:0]   message_handle,
  input  logic [mqrm_pkg::SIZE_W-1:0]     message_size,
  output logic [1:0]                      status,
  output logic [mqrm_pkg::QID_W-1:0]      allocated_queue,
  output logic [mqrm_pkg::HANDLE_W-1:0]   handle_out,
  output logic [mqrm_pkg::SIZE_W-1:0]     size_out
);
  import mqrm_pkg::*;

  localparam int QW    = $clog2(QUEUE_COUNT);
  localparam int SW    = $clog2(SLOTS_PER_QUEUE);
  localparam int DEPTH = QUEUE_COUNT * SLOTS_PER_QUEUE;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [QID_W:0]  QCNT      = QUEUE_COUNT[QID_W:0];
  localparam logic [QID_W:0]  SCNT      = STATIC_QUEUES[QID_W:0];
  localparam logic [SW-1:0]   LAST_SLOT = SW'(SLOTS_PER_QUEUE - 1);
  localparam logic [AW-1:0]   SLOTS_A   = AW'(SLOTS_PER_QUEUE);

  mqrm_mode_t                mode_q;
  logic [QID_W-1:0]          qid_q;
  logic [HANDLE_W-1:0]       handle_q;
  logic [SIZE_W-1:0]         size_q;

  logic [SW-1:0]             wslot [QUEUE_COUNT];
  logic [SW-1:0]             rslot [QUEUE_COUNT];
  logic [QUEUE_COUNT-1:0]    taken;

  logic [HANDLE_W-1:0]       handle_mem [DEPTH];
  logic [SIZE_W-1:0]         size_mem [DEPTH];
  logic [HANDLE_W-1:0]       handle_rd;
  logic [SIZE_W-1:0]         size_rd;

  mqrm_status_t              status_q, status_next;
  logic [QID_W-1:0]          alloc_q, alloc_next;
  logic                      pop_q;

  logic                      id_ok, del_ok, full, empty;
  logic [QW-1:0]             q_idx;
  logic [SW-1:0]             wr_ptr, rd_ptr, wr_nx, rd_nx;
  logic                      free_found;
  logic [QW-1:0]             free_idx;
  logic                      push, pop, claim, release_q;
  logic [AW-1:0]             mem_addr;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_q   <= mqrm_mode_t'(mode);
      qid_q    <= queue_sel;
      handle_q <= message_handle;
      size_q   <= message_size;
    end
  end

  always_comb begin
    id_ok  = {1'b0, qid_q} < QCNT;
    del_ok = id_ok && ({1'b0, qid_q} >= SCNT);
    q_idx  = id_ok ? qid_q[QW-1:0] : '0;
    wr_ptr = wslot[q_idx];
    rd_ptr = rslot[q_idx];
    wr_nx  = (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
    rd_nx  = (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
    full   = (wr_nx == rd_ptr);
    empty  = (wr_ptr == rd_ptr);
  end

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = QUEUE_COUNT - 1; i >= 0; i--) begin
      if (i >= STATIC_QUEUES && !taken[i]) begin
        free_found = 1'b1;
        free_idx   = QW'(i);
      end
    end
  end

  always_comb begin
    status_next = STAT_OK;
    alloc_next  = '0;
    push        = 1'b0;
    pop         = 1'b0;
    claim       = 1'b0;
    release_q   = 1'b0;
    case (mode_q)
      MODE_SEND: begin
        if (!id_ok) begin
          status_next = STAT_BAD_ID;
        end else if (full) begin
          status_next = STAT_FULL;
        end else begin
          push = 1'b1;
        end
      end
      MODE_RECV: begin
        if (!id_ok) begin
          status_next = STAT_BAD_ID;
        end else if (empty) begin
          status_next = STAT_NO_DATA;
        end else begin
          pop = 1'b1;
        end
      end
      MODE_CREATE: begin
        if (free_found) begin
          claim      = 1'b1;
          alloc_next = QID_W'(free_idx);
        end else begin
          status_next = STAT_FULL;
        end
      end
      MODE_DELETE: begin
        if (del_ok) begin
          release_q = 1'b1;
        end else begin
          status_next = STAT_BAD_ID;
        end
      end
      default: begin
        status_next = STAT_BAD_ID;
      end
    endcase
    mem_addr = AW'(q_idx) * SLOTS_A + AW'(push ? wr_ptr : rd_ptr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < QUEUE_COUNT; i++) begin
        wslot[i] <= '0;
        rslot[i] <= '0;
      end
      taken <= '0;
    end else if (cmd.execute) begin
      if (push) begin
        wslot[q_idx] <= wr_nx;
      end
      if (pop) begin
        rslot[q_idx] <= rd_nx;
      end
      if (claim) begin
        taken[free_idx] <= 1'b1;
      end
      if (release_q) begin
        taken[q_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      if (push) begin
        handle_mem[mem_addr] <= handle_q;
        size_mem[mem_addr]   <= size_q;
      end
      handle_rd <= handle_mem[mem_addr];
      size_rd   <= size_mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      status_q <= status_next;
      alloc_q  <= alloc_next;
      pop_q    <= pop;
    end
  end

  assign status          = status_q;
  assign allocated_queue = alloc_q;
  assign handle_out      = pop_q ? handle_rd : '0;
  assign size_out        = pop_q ? size_rd : '0;

endmodule

`default_nettype wire

FILE: src/mqrm_checker.sv
// Port-level checks of the mailbox timing and result encoding.
// Depends on mqrm_pkg; bound to multi_queue_ring_mailbox_unit below.
`default_nettype none

module mqrm_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            start,
  input logic                            busy,
  input logic                            done,
  input logic [1:0]                      status,
  input logic [mqrm_pkg::QID_W-1:0]      allocated_queue,
  input logic [mqrm_pkg::HANDLE_W-1:0]   handle_out,
  input logic [mqrm_pkg::SIZE_W-1:0]     size_out
);
  import mqrm_pkg::*;

  a_done_while_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("done without busy");

  a_accept_then_exec: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("no execute cycle after accept");

  a_accept_then_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("done missing two cycles after accept");

  a_fail_no_payload: assert property (@(posedge clk) disable iff (rst)
    (done && status != STAT_OK) |-> (handle_out == '0 && size_out == '0))
    else $error("payload on failed word");

  a_fail_no_alloc: assert property (@(posedge clk) disable iff (rst)
    (done && status != STAT_OK) |-> (allocated_queue == '0))
    else $error("queue id on failed word");

endmodule

bind multi_queue_ring_mailbox_unit mqrm_checker u_mqrm_checker (
  .clk             (clk),
  .rst             (rst),
  .start           (start),
  .busy            (busy),
  .done            (done),
  .status          (status),
  .allocated_queue (allocated_queue),
  .handle_out      (handle_out),
  .size_out        (size_out)
);

`default_nettype wire

FILE: verif/multi_queue_ring_mailbox_unit_checker.sv
// Checker for the multi-queue ring mailbox: watches the request and reply ports,
// keeps its own copy of the rings and claim flags, and compares every reply.
// Depends on mqrm_pkg; instantiated by multi_queue_ring_mailbox_unit_tb.
`timescale 1ns / 1ps

module multi_queue_ring_mailbox_unit_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic [1:0]                    mode,
  input  logic [mqrm_pkg::QID_W-1:0]    queue_sel,
  input  logic [mqrm_pkg::HANDLE_W-1:0] message_handle,
  input  logic [mqrm_pkg::SIZE_W-1:0]   message_size,
  input  logic                          done,
  input  logic [1:0]                    status,
  input  logic [mqrm_pkg::QID_W-1:0]    allocated_queue,
  input  logic [mqrm_pkg::HANDLE_W-1:0] handle_out,
  input  logic [mqrm_pkg::SIZE_W-1:0]   size_out,
  output int unsigned                   fail_count,
  output int unsigned                   pending
);
  import mqrm_pkg::*;

  localparam int QCOUNT  = DEF_QUEUE_COUNT;
  localparam int STATICS = DEF_STATIC_QUEUES;
  localparam int SLOTS   = DEF_SLOTS_PER_QUEUE;
  localparam int PTR_W   = $clog2(SLOTS);

  typedef struct packed {
    mqrm_status_t        status;
    logic [QID_W-1:0]    alloc;
    logic [HANDLE_W-1:0] handle;
    logic [SIZE_W-1:0]   size;
  } mailbox_reply_t;

  mailbox_reply_t      replies_due[$];
  logic [PTR_W-1:0]    wr_ptr     [QCOUNT];
  logic [PTR_W-1:0]    rd_ptr     [QCOUNT];
  logic [HANDLE_W-1:0] handle_mem [QCOUNT][SLOTS];
  logic [SIZE_W-1:0]   size_mem   [QCOUNT][SLOTS];
  logic                claimed    [QCOUNT];
  int unsigned         failures;

  function automatic mailbox_reply_t apply_request(mqrm_mode_t m, logic [QID_W-1:0] q,
                                                   logic [HANDLE_W-1:0] h,
                                                   logic [SIZE_W-1:0] s);
    mailbox_reply_t r;
    int qi;
    int nxt;
    int i;
    r = '0;
    r.status = STAT_OK;
    qi = int'(q);
    case (m)
      MODE_SEND: begin
        if (qi >= QCOUNT) begin
          r.status = STAT_BAD_ID;
        end else begin
          nxt = (int'(wr_ptr[qi]) + 1) % SLOTS;
          if (nxt == int'(rd_ptr[qi])) begin
            r.status = STAT_FULL;
          end else begin
            handle_mem[qi][wr_ptr[qi]] = h;
            size_mem[qi][wr_ptr[qi]]   = s;
            wr_ptr[qi] = PTR_W'(nxt);
          end
        end
      end
      MODE_RECV: begin
        if (qi >= QCOUNT) begin
          r.status = STAT_BAD_ID;
        end else if (rd_ptr[qi] == wr_ptr[qi]) begin
          r.status = STAT_NO_DATA;
        end else begin
          r.handle = handle_mem[qi][rd_ptr[qi]];
          r.size   = size_mem[qi][rd_ptr[qi]];
          rd_ptr[qi] = PTR_W'((int'(rd_ptr[qi]) + 1) % SLOTS);
        end
      end
      MODE_CREATE: begin
        r.status = STAT_FULL;
        for (i = STATICS; i < QCOUNT; i++) begin
          if (!claimed[i] && r.status == STAT_FULL) begin
            claimed[i] = 1'b1;
            r.alloc    = QID_W'(i);
            r.status   = STAT_OK;
          end
        end
      end
      default: begin
        if (qi < STATICS || qi >= QCOUNT) r.status = STAT_BAD_ID;
        else claimed[qi] = 1'b0;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    mailbox_reply_t due;
    mailbox_reply_t seen;
    if (rst) begin
      for (int i = 0; i < QCOUNT; i++) begin
        wr_ptr[i]  = '0;
        rd_ptr[i]  = '0;
        claimed[i] = 1'b0;
      end
      replies_due.delete();
    end else begin
      if (done) begin
        seen.status = mqrm_status_t'(status);
        seen.alloc  = allocated_queue;
        seen.handle = handle_out;
        seen.size   = size_out;
        if (replies_due.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("%0t: reply with no word outstanding: status %0d alloc %0d %s",
                     $realtime, seen.status, seen.alloc,
                     $sformatf("handle %h size %h", seen.handle, seen.size));
        end else begin
          due = replies_due.pop_front();
          if (seen.status !== due.status || seen.alloc !== due.alloc ||
              seen.handle !== due.handle || seen.size !== due.size) begin
            failures++;
            if (failures <= 10)
              $display("%0t: reply mismatch: exp %s, got %s", $realtime,
                       $sformatf("status %0d alloc %0d handle %h size %h",
                                 due.status, due.alloc, due.handle, due.size),
                       $sformatf("status %0d alloc %0d handle %h size %h",
                                 seen.status, seen.alloc, seen.handle, seen.size));
          end
        end
      end
      if (start && !busy)
        replies_due.push_back(apply_request(mqrm_mode_t'(mode), queue_sel,
                                            message_handle, message_size));
    end
    fail_count <= failures;
    pending    <= replies_due.size();
  end

endmodule

FILE: verif/multi_queue_ring_mailbox_unit_tb.sv
// Testbench top for the multi-queue ring mailbox: clock, reset, request words
// and the verdict. Depends on mqrm_pkg, the unit and its checker module.
`timescale 1ns / 1ps

module multi_queue_ring_mailbox_unit_tb;
  import mqrm_pkg::*;

  localparam int WORDS          = 1650;
  localparam int WATCHDOG_LIMIT = 500;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic [1:0]          mode;
  logic [QID_W-1:0]    queue_sel;
  logic [HANDLE_W-1:0] message_handle;
  logic [SIZE_W-1:0]   message_size;
  logic                done;
  logic [1:0]          status;
  logic [QID_W-1:0]    allocated_queue;
  logic [HANDLE_W-1:0] handle_out;
  logic [SIZE_W-1:0]   size_out;
  int unsigned         fail_count;
  int unsigned         pending;
  int unsigned         words_sent;
  int unsigned         quiet_cycles;

  multi_queue_ring_mailbox_unit DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode),
    .queue_sel(queue_sel), .message_handle(message_handle), .message_size(message_size),
    .done(done), .status(status), .allocated_queue(allocated_queue),
    .handle_out(handle_out), .size_out(size_out)
  );

  multi_queue_ring_mailbox_unit_checker checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode),
    .queue_sel(queue_sel), .message_handle(message_handle), .message_size(message_size),
    .done(done), .status(status), .allocated_queue(allocated_queue),
    .handle_out(handle_out), .size_out(size_out),
    .fail_count(fail_count), .pending(pending)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[multi_queue_ring_mailbox_unit] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic drive_word(input mqrm_mode_t m, input logic [QID_W-1:0] q,
                            input logic [HANDLE_W-1:0] h, input logic [SIZE_W-1:0] s);
    bit may_idle;
    may_idle = !(words_sent >= 700 && words_sent < 1000);
    @(negedge clk);
    while (may_idle && $urandom_range(0, 99) < 8) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start          <= 1'b1;
    mode           <= m;
    queue_sel      <= q;
    message_handle <= h;
    message_size   <= s;
    @(posedge clk);
    while (busy) @(posedge clk);
    words_sent++;
  endtask

  function automatic logic [HANDLE_W-1:0] pick_handle();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return '1;
      default: return SIZE_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [QID_W-1:0] pick_queue();
    if ($urandom_range(0, 99) < 88) return QID_W'($urandom_range(0, 15));
    return QID_W'($urandom_range(16, 31));
  endfunction

  initial begin
    int n;
    int k;
    int sel;
    logic [QID_W-1:0] q;
    rst            = 1'b1;
    start          = 1'b0;
    mode           = MODE_SEND;
    queue_sel      = '0;
    message_handle = '0;
    message_size   = '0;
    words_sent     = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    drive_word(MODE_RECV,   5'd0,  '0, '0);
    drive_word(MODE_SEND,   5'd0,  '0, '0);
    drive_word(MODE_SEND,   5'd0,  '1, '1);
    drive_word(MODE_SEND,   5'd15, pick_handle(), pick_size());
    drive_word(MODE_RECV,   5'd0,  '0, '0);
    drive_word(MODE_RECV,   5'd0,  '0, '0);
    drive_word(MODE_RECV,   5'd15, '0, '0);
    drive_word(MODE_SEND,   5'd16, pick_handle(), pick_size());
    drive_word(MODE_SEND,   5'd31, '1, '1);
    drive_word(MODE_RECV,   5'd31, '0, '0);
    drive_word(MODE_DELETE, 5'd0,  '0, '0);
    drive_word(MODE_DELETE, 5'd7,  '0, '0);
    drive_word(MODE_DELETE, 5'd16, '0, '0);
    drive_word(MODE_DELETE, 5'd8,  '0, '0);
    repeat (8) drive_word(MODE_CREATE, '1, '0, '0);
    drive_word(MODE_CREATE, 5'd0,  '0, '0);
    drive_word(MODE_DELETE, 5'd12, '0, '0);
    drive_word(MODE_CREATE, 5'd0,  '0, '0);

    while (words_sent < WORDS) begin
      if ($urandom_range(0, 9) < 4) begin
        q = QID_W'($urandom_range(0, 15));
        n = $urandom_range(1, 18);
        repeat (n) drive_word(MODE_SEND, q, pick_handle(), pick_size());
        k = $urandom_range(0, n + 2);
        repeat (k) drive_word(MODE_RECV, q, pick_handle(), pick_size());
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 35) begin
          drive_word(MODE_SEND, pick_queue(), pick_handle(), pick_size());
        end else if (sel < 70) begin
          drive_word(MODE_RECV, pick_queue(), pick_handle(), pick_size());
        end else if (sel < 85) begin
          drive_word(MODE_CREATE, QID_W'($urandom_range(0, 31)), pick_handle(), pick_size());
        end else if ($urandom_range(0, 9) < 7) begin
          drive_word(MODE_DELETE, QID_W'($urandom_range(8, 15)), pick_handle(), pick_size());
        end else begin
          drive_word(MODE_DELETE, QID_W'($urandom_range(0, 31)), pick_handle(), pick_size());
        end
      end
    end

    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[multi_queue_ring_mailbox_unit] OK");
    end else begin
      $display("[multi_queue_ring_mailbox_unit] ERROR");
    end
    $finish;
  end

endmodule
